/* src/hpt_pkg.sv */
// ----------------------------------------------------------------------------
// Homogeneous point transform package
// Shared widths, codes, configuration and payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package hpt_pkg;

  localparam int COORD_BITS = 48;
  localparam int COEF_BITS  = 32;
  localparam int COEF_FRAC  = COEF_BITS - 2;
  localparam int CFG_DATA_W = 64;
  localparam int HALF_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int MAG_W      = COORD_BITS + COEF_BITS;
  localparam int NUM_W      = MAG_W + 1;
  localparam int LO_W       = COORD_BITS / 2;
  localparam int HI_W       = COORD_BITS - LO_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COEF_BITS-1:0]  coef_t;

  localparam coef_t COEF_ONE = coef_t'(1 << COEF_FRAC);

  typedef enum logic [1:0] {
    OUT_OK   = 2'd0,
    OUT_NULL = 2'd1,
    OUT_INF  = 2'd2
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_R00_R01 = 3'd0,
    REG_R02_R10 = 3'd1,
    REG_R11_R12 = 3'd2,
    REG_R20_R21 = 3'd3,
    REG_R22_W   = 3'd4,
    REG_SHIFT_X = 3'd5,
    REG_SHIFT_Y = 3'd6,
    REG_SHIFT_Z = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][2:0][COEF_BITS-1:0] m;
    logic [COEF_BITS-1:0]           w;
    logic [2:0][COORD_BITS-1:0]     t;
  } cfg_t;

  typedef struct packed {
    logic   mode;
    logic   has_value;
    logic   is_cartesian;
    coord_t coord_x;
    coord_t coord_y;
    coord_t coord_z;
  } in_item_t;

  typedef struct packed {
    outcome_t outcome;
    coord_t   out_x;
    coord_t   out_y;
    coord_t   out_z;
    logic     saturated;
  } out_item_t;

  typedef struct packed {
    outcome_t                outcome;
    logic [2:0][NUM_W-1:0]   num;
  } mid_t;

endpackage

`default_nettype wire

/* src/hpt_front.sv */
// ----------------------------------------------------------------------------
// Homogeneous point transform front end
// Accepts, classifies and forms exact numerators R*c + T, or R*c when mode=1.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_front import hpt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire in_item_t in_data,
  input  wire logic     fifo_full,
  output logic          push,
  output mid_t          push_data
);

  logic en;

  logic     v0_r, v1_r, v2_r, v3_r, v4_r;
  in_item_t item0_r;
  outcome_t oc1_r, oc2_r, oc3_r, oc4_r;
  logic     mode1_r;

  logic signed [HI_W+COEF_BITS-1:0]   ph1_r [3][3];
  logic signed [LO_W+COEF_BITS:0]     pl1_r [3][3];
  logic signed [MAG_W-1:0]            prod2_r [3][3];
  logic signed [MAG_W-1:0]            t2_r [3];
  logic signed [NUM_W-1:0]            a3_r [3];
  logic signed [NUM_W-1:0]            b3_r [3];
  logic signed [NUM_W-1:0]            num4_r [3];

  coord_t   c0 [3];
  outcome_t oc_nxt;

  assign en      = !fifo_full;
  assign in_full = fifo_full;
  assign push    = en && v4_r;

  always_comb begin
    c0[0] = item0_r.coord_x;
    c0[1] = item0_r.coord_y;
    c0[2] = item0_r.coord_z;
    if (!item0_r.has_value || !item0_r.is_cartesian) begin
      oc_nxt = OUT_NULL;
    end else if (cfg.w == '0) begin
      oc_nxt = OUT_INF;
    end else begin
      oc_nxt = OUT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_push;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item0_r <= in_data;
      oc1_r   <= oc_nxt;
      mode1_r <= item0_r.mode;
      oc2_r   <= oc1_r;
      oc3_r   <= oc2_r;
      oc4_r   <= oc3_r;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ph1_r[i][j] <= (HI_W+COEF_BITS)'($signed(c0[j][COORD_BITS-1:LO_W])) *
                         (HI_W+COEF_BITS)'($signed(cfg.m[i][j]));
          pl1_r[i][j] <= (LO_W+COEF_BITS+1)'($signed({1'b0, c0[j][LO_W-1:0]})) *
                         (LO_W+COEF_BITS+1)'($signed(cfg.m[i][j]));
          prod2_r[i][j] <= $signed({ph1_r[i][j], {LO_W{1'b0}}}) + MAG_W'(pl1_r[i][j]);
        end
        if (mode1_r) begin
          t2_r[i] <= '0;
        end else begin
          t2_r[i] <= MAG_W'($signed({cfg.t[i], {COEF_FRAC{1'b0}}}));
        end
        a3_r[i]   <= NUM_W'(prod2_r[i][0]) + NUM_W'(prod2_r[i][1]);
        b3_r[i]   <= NUM_W'(prod2_r[i][2]) + NUM_W'(t2_r[i]);
        num4_r[i] <= a3_r[i] + b3_r[i];
      end
    end
  end

  always_comb begin
    push_data.outcome = oc4_r;
    for (int i = 0; i < 3; i++) begin
      push_data.num[i] = num4_r[i];
    end
  end

endmodule

`default_nettype wire

/* src/hpt_fifo.sv */
// ----------------------------------------------------------------------------
// Homogeneous point transform decoupling queue
// Short queue of numerators between the front end and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_fifo import hpt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire mid_t push_data,
  output logic      full,
  input  wire logic pop,
  output mid_t      pop_data,
  output logic      empty
);

  mid_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* src/hpt_back.sv */
// ----------------------------------------------------------------------------
// Homogeneous point transform back end
// Divides the numerators by w one quotient bit per stage, saturates, outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_back import hpt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire mid_t  fifo_data,
  input  wire logic  fifo_empty,
  output logic       fifo_pop,
  output logic       out_empty,
  input  wire logic  out_pop,
  output out_item_t  out_data
);

  logic                 en;
  logic                 wneg;
  logic [COEF_BITS-1:0] wmag;

  logic                 b0v_r;
  outcome_t             b0oc_r;
  logic [2:0]           b0neg_r;
  logic [MAG_W-1:0]     b0mag_r [3];

  logic                  dv_r  [COORD_BITS+1];
  outcome_t              doc_r [COORD_BITS+1];
  logic [2:0]            dneg_r [COORD_BITS+1];
  logic [2:0]            dovf_r [COORD_BITS+1];
  logic [COEF_BITS-1:0]  rem_r [COORD_BITS+1][3];
  logic [COORD_BITS-1:0] wd_r  [COORD_BITS+1][3];

  logic [COEF_BITS-1:0]  rem_nxt [COORD_BITS][3];
  logic [COORD_BITS-1:0] wd_nxt  [COORD_BITS][3];
  logic [COEF_BITS:0]    trial;
  logic                  ge;

  logic [NUM_W-1:0]      nv, av;
  logic [2:0]            neg_nxt;
  logic [MAG_W-1:0]      mag_nxt [3];

  logic                  out_v_r;
  out_item_t             out_data_r, res_nxt;
  logic [COORD_BITS-1:0] q, lim, val, rv [3];
  logic                  qneg, sat;
  logic [2:0]            sat_v;

  assign en        = !out_v_r || out_pop;
  assign fifo_pop  = en && !fifo_empty;
  assign out_empty = !out_v_r;
  assign out_data  = out_data_r;

  assign wneg = cfg.w[COEF_BITS-1];
  assign wmag = wneg ? (~cfg.w + 1'b1) : cfg.w;

  always_comb begin
    nv = '0;
    av = '0;
    for (int i = 0; i < 3; i++) begin
      nv         = fifo_data.num[i];
      av         = nv[NUM_W-1] ? (~nv + 1'b1) : nv;
      neg_nxt[i] = nv[NUM_W-1] ^ wneg;
      mag_nxt[i] = av[MAG_W-1:0];
    end
  end

  always_comb begin
    trial = '0;
    ge    = 1'b0;
    for (int k = 0; k < COORD_BITS; k++) begin
      for (int i = 0; i < 3; i++) begin
        trial = {rem_r[k][i], wd_r[k][i][COORD_BITS-1]};
        ge    = (trial >= {1'b0, wmag});
        if (ge) begin
          rem_nxt[k][i] = COEF_BITS'(trial - {1'b0, wmag});
        end else begin
          rem_nxt[k][i] = trial[COEF_BITS-1:0];
        end
        wd_nxt[k][i] = {wd_r[k][i][COORD_BITS-2:0], ge};
      end
    end
  end

  always_comb begin
    q     = '0;
    lim   = '0;
    val   = '0;
    qneg  = 1'b0;
    sat   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      q     = wd_r[COORD_BITS][i];
      qneg  = dneg_r[COORD_BITS][i] && (dovf_r[COORD_BITS][i] || (q != '0));
      lim   = qneg ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
      sat   = dovf_r[COORD_BITS][i] || (q > lim);
      val   = sat ? lim : q;
      rv[i] = qneg ? (~val + 1'b1) : val;
      sat_v[i] = sat;
    end
    res_nxt.outcome = doc_r[COORD_BITS];
    if (doc_r[COORD_BITS] == OUT_OK) begin
      res_nxt.out_x     = rv[0];
      res_nxt.out_y     = rv[1];
      res_nxt.out_z     = rv[2];
      res_nxt.saturated = |sat_v;
    end else begin
      res_nxt.out_x     = '0;
      res_nxt.out_y     = '0;
      res_nxt.out_z     = '0;
      res_nxt.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0v_r   <= 1'b0;
      out_v_r <= 1'b0;
      for (int k = 0; k <= COORD_BITS; k++) begin
        dv_r[k] <= 1'b0;
      end
    end else if (en) begin
      b0v_r   <= fifo_pop;
      dv_r[0] <= b0v_r;
      for (int k = 0; k < COORD_BITS; k++) begin
        dv_r[k+1] <= dv_r[k];
      end
      out_v_r <= dv_r[COORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0oc_r  <= fifo_data.outcome;
      b0neg_r <= neg_nxt;
      doc_r[0]  <= b0oc_r;
      dneg_r[0] <= b0neg_r;
      for (int i = 0; i < 3; i++) begin
        b0mag_r[i]   <= mag_nxt[i];
        rem_r[0][i]  <= b0mag_r[i][MAG_W-1:COORD_BITS];
        wd_r[0][i]   <= b0mag_r[i][COORD_BITS-1:0];
        dovf_r[0][i] <= (b0mag_r[i][MAG_W-1:COORD_BITS] >= wmag);
      end
      for (int k = 0; k < COORD_BITS; k++) begin
        doc_r[k+1]  <= doc_r[k];
        dneg_r[k+1] <= dneg_r[k];
        dovf_r[k+1] <= dovf_r[k];
        for (int i = 0; i < 3; i++) begin
          rem_r[k+1][i] <= rem_nxt[k][i];
          wd_r[k+1][i]  <= wd_nxt[k][i];
        end
      end
      out_data_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/homogeneous_point_transform_core.sv */
// Throughput: one beat per cycle unless in_full or an unpopped result stalls;
// the quotient comes from a 48-stage divider pipeline, one quotient bit per
// stage, shared by nothing else.
// A 4-entry queue decouples front end and divider; full rises when it fills.
// Reset (rst_n low, synchronous) empties all stages and loads identity
// coefficients, w = 1.0 and zero translation.
// ----------------------------------------------------------------------------
// Homogeneous point transform core
// Configuration registers, front end, decoupling queue and divider back end.
// ----------------------------------------------------------------------------
`default_nettype none

module homogeneous_point_transform_core import hpt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire in_item_t              in_data,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output out_item_t                  out_data
);

  cfg_t cfg_r, cfg_nxt, cfg_rst;
  logic fifo_full, fifo_empty, fifo_push, fifo_pop;
  mid_t fifo_wdata, fifo_rdata;

  always_comb begin
    cfg_rst         = '0;
    cfg_rst.m[0][0] = COEF_ONE;
    cfg_rst.m[1][1] = COEF_ONE;
    cfg_rst.m[2][2] = COEF_ONE;
    cfg_rst.w       = COEF_ONE;
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_R00_R01: begin
          cfg_nxt.m[0][0] = cfg_data[COEF_BITS-1:0];
          cfg_nxt.m[0][1] = cfg_data[HALF_W +: COEF_BITS];
        end
        REG_R02_R10: begin
          cfg_nxt.m[0][2] = cfg_data[COEF_BITS-1:0];
          cfg_nxt.m[1][0] = cfg_data[HALF_W +: COEF_BITS];
        end
        REG_R11_R12: begin
          cfg_nxt.m[1][1] = cfg_data[COEF_BITS-1:0];
          cfg_nxt.m[1][2] = cfg_data[HALF_W +: COEF_BITS];
        end
        REG_R20_R21: begin
          cfg_nxt.m[2][0] = cfg_data[COEF_BITS-1:0];
          cfg_nxt.m[2][1] = cfg_data[HALF_W +: COEF_BITS];
        end
        REG_R22_W: begin
          cfg_nxt.m[2][2] = cfg_data[COEF_BITS-1:0];
          cfg_nxt.w       = cfg_data[HALF_W +: COEF_BITS];
        end
        REG_SHIFT_X: cfg_nxt.t[0] = cfg_data[COORD_BITS-1:0];
        REG_SHIFT_Y: cfg_nxt.t[1] = cfg_data[COORD_BITS-1:0];
        REG_SHIFT_Z: cfg_nxt.t[2] = cfg_data[COORD_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cfg_rst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hpt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .fifo_full (fifo_full),
    .push      (fifo_push),
    .push_data (fifo_wdata)
  );

  hpt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_data (fifo_wdata),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .pop_data  (fifo_rdata),
    .empty     (fifo_empty)
  );

  hpt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .fifo_data  (fifo_rdata),
    .fifo_empty (fifo_empty),
    .fifo_pop   (fifo_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data)
  );

`ifndef SYNTHESIS
  a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.outcome != OUT_OK) |->
      (out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_z == '0 &&
       !out_data.saturated))
    else $error("non-transformed result carries data");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.saturated) |->
      (out_data.out_x == {1'b1, {(COORD_BITS-1){1'b0}}} ||
       out_data.out_x == {1'b0, {(COORD_BITS-1){1'b1}}} ||
       out_data.out_y == {1'b1, {(COORD_BITS-1){1'b0}}} ||
       out_data.out_y == {1'b0, {(COORD_BITS-1){1'b1}}} ||
       out_data.out_z == {1'b1, {(COORD_BITS-1){1'b0}}} ||
       out_data.out_z == {1'b0, {(COORD_BITS-1){1'b1}}}))
    else $error("saturated result without a clipped coordinate");

  a_full_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> fifo_full && !fifo_push)
    else $error("front end advanced into a full queue");
`endif

endmodule

`default_nettype wire
